// File: rtl/dxpc_pkg.sv
// ----------------------------------------------------------------------------
// Distinct xy point counter package
// Shared widths, the token that travels down the cell chain, and the IEEE
// single equality used by every cell.
// ----------------------------------------------------------------------------
`default_nettype none

package dxpc_pkg;

  localparam int unsigned COORD_W        = 32;
  localparam int unsigned COUNT_W        = 9;
  localparam int unsigned COUNT_MAX      = 511;
  localparam int unsigned MAX_POINTS_DEF = 256;

  // One point on its way down the chain.
  // done:   a cell already matched or stored this point
  // stored: the point took a cell of its own
  typedef struct packed {
    logic               vld;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               last;
    logic               done;
    logic               stored;
  } token_t;

  function automatic logic is_nan(input logic [COORD_W-1:0] v);
    return (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
  endfunction

  function automatic logic is_zero(input logic [COORD_W-1:0] v);
    return v[30:0] == 31'd0;
  endfunction

  // IEEE equality: NaN matches nothing, +0 matches -0.
  function automatic logic coord_eq(input logic [COORD_W-1:0] a,
                                    input logic [COORD_W-1:0] b);
    logic eq;
    if (is_nan(a) || is_nan(b)) begin
      eq = 1'b0;
    end else if (is_zero(a) && is_zero(b)) begin
      eq = 1'b1;
    end else begin
      eq = (a == b);
    end
    return eq;
  endfunction

endpackage

`default_nettype wire

// File: rtl/dxpc_if.sv
// ----------------------------------------------------------------------------
// Distinct xy point counter channels
// Valid/ready channels for incoming points and for finished-set results.
// ----------------------------------------------------------------------------
`default_nettype none

interface dxpc_point_if;
  logic                         valid;
  logic                         ready;
  logic [dxpc_pkg::COORD_W-1:0] point_x;
  logic [dxpc_pkg::COORD_W-1:0] point_y;
  logic                         last_point;

  modport source (output valid, point_x, point_y, last_point, input ready);
  modport sink   (input valid, point_x, point_y, last_point, output ready);
endinterface

interface dxpc_result_if;
  logic                         valid;
  logic                         ready;
  logic [dxpc_pkg::COUNT_W-1:0] distinct_count;
  logic                         table_overflow;

  modport source (output valid, distinct_count, table_overflow, input ready);
  modport sink   (input valid, distinct_count, table_overflow, output ready);
endinterface

`default_nettype wire

// File: rtl/dxpc_cell.sv
// ----------------------------------------------------------------------------
// Distinct xy point counter cell
// Holds one stored pair; checks the passing point against it, claims the
// cell for a new point, and frees it when the last point of a set passes.
// ----------------------------------------------------------------------------
`default_nettype none

module dxpc_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  dxpc_pkg::token_t tok_i,
  output dxpc_pkg::token_t tok_o
);
  import dxpc_pkg::*;

  logic               key_vld_q, key_vld_d;
  logic [COORD_W-1:0] key_x_q, key_y_q;
  token_t             tok_q, tok_d;
  logic               match, take;

  always_comb begin
    match = key_vld_q && coord_eq(key_x_q, tok_i.x) && coord_eq(key_y_q, tok_i.y);
    take  = tok_i.vld && !tok_i.done && !key_vld_q;

    tok_d = tok_i;
    if (tok_i.vld && !tok_i.done && (match || take)) begin
      tok_d.done   = 1'b1;
      tok_d.stored = take;
    end

    key_vld_d = key_vld_q;
    if (take) begin
      key_vld_d = 1'b1;
    end
    // free the cell once the set is finished
    if (tok_i.vld && tok_i.last) begin
      key_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_vld_q <= 1'b0;
      tok_q     <= '0;
    end else if (en_i) begin
      key_vld_q <= key_vld_d;
      tok_q     <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && take) begin
      key_x_q <= tok_i.x;
      key_y_q <= tok_i.y;
    end
  end

  assign tok_o = tok_q;

endmodule

`default_nettype wire

// File: rtl/dxpc_tally.sv
// ----------------------------------------------------------------------------
// Distinct xy point counter tally
// Counts points that took a cell, flags points that found the chain full,
// and holds the result of a finished set in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dxpc_tally #(
  parameter int unsigned MAX_POINTS = dxpc_pkg::MAX_POINTS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  dxpc_pkg::token_t             tok_i,
  input  logic                         out_ready_i,
  output logic                         en_o,
  output logic                         out_valid_o,
  output logic [dxpc_pkg::COUNT_W-1:0] distinct_count_o,
  output logic                         table_overflow_o
);
  import dxpc_pkg::*;

  localparam int unsigned CW = $clog2(MAX_POINTS + 1);

  logic [CW-1:0]      cnt_q, cnt_d;
  logic               ovf_q, ovf_d;
  logic               out_valid_q;
  logic [COUNT_W-1:0] count_q, cnt_sat;
  logic               ovf_out_q;
  logic [31:0]        cnt_ext;
  logic               en;

  // advance the chain whenever the result slot is free or being drained
  assign en = !out_valid_q || out_ready_i;

  always_comb begin
    cnt_d = cnt_q + {{(CW-1){1'b0}}, tok_i.stored};
    ovf_d = ovf_q || !tok_i.done;
    cnt_ext = 32'(cnt_d);
    cnt_sat = (cnt_ext > 32'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX) : cnt_ext[COUNT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (en && tok_i.vld) begin
        if (tok_i.last) begin
          cnt_q       <= '0;
          ovf_q       <= 1'b0;
          out_valid_q <= 1'b1;
        end else begin
          cnt_q       <= cnt_d;
          ovf_q       <= ovf_d;
          out_valid_q <= 1'b0;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && tok_i.vld && tok_i.last) begin
      count_q   <= cnt_sat;
      ovf_out_q <= ovf_d;
    end
  end

  assign en_o             = en;
  assign out_valid_o      = out_valid_q;
  assign distinct_count_o = count_q;
  assign table_overflow_o = ovf_out_q;

`ifndef ASSERT_OFF
  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_POINTS))
    else $error("tally count beyond chain length");

  a_ovf_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (cnt_q == CW'(MAX_POINTS)))
    else $error("overflow flagged while chain not full");

  a_last_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && tok_i.vld && tok_i.last) |=> out_valid_q)
    else $error("last point left the chain without a result");
`endif

endmodule

`default_nettype wire

// File: rtl/distinct_xy_point_counter_unit.sv
// Path: the result of a set is valid once its last point has passed every cell
//   register and then the output register; stalls add to the wait.
// Throughput: one point per cycle; the whole chain advances together and
//   halts only while a finished result waits in the output register.
// Reset: clears every cell's occupancy, the chain tokens and the tally.
//   No clearing pass; points are taken from the first cycle after reset.
// ----------------------------------------------------------------------------
// Distinct xy point counter unit
// Counts distinct (x,y) pairs in a set of points using a systolic chain of
// key cells, one stored pair per cell.
// ----------------------------------------------------------------------------
`default_nettype none

module distinct_xy_point_counter_unit #(
  parameter int unsigned MAX_POINTS = dxpc_pkg::MAX_POINTS_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  dxpc_point_if.sink    point_i,
  dxpc_result_if.source result_o
);
  import dxpc_pkg::*;

  // Each point walks the chain one cell per cycle while the chain advances. A
  // cell that already holds an equal pair marks the point done; the first empty
  // cell it meets claims it. Points keep their order, so a later point always
  // sees every pair an earlier point stored. The last point of a set frees each
  // cell behind it, so the next set starts on an empty chain without a gap.
  token_t chain [MAX_POINTS+1];
  logic   en;

  // A point enters whenever the chain advances; the enable is the ready.
  assign chain[0] = '{vld:    point_i.valid,
                      x:      point_i.point_x,
                      y:      point_i.point_y,
                      last:   point_i.last_point,
                      done:   1'b0,
                      stored: 1'b0};

  assign point_i.ready = en;

  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
    dxpc_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .tok_i  (chain[i]),
      .tok_o  (chain[i+1])
    );
  end

  // A point leaving not done found the chain full: flag it as overflow.
  dxpc_tally #(
    .MAX_POINTS (MAX_POINTS)
  ) u_tally (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .tok_i            (chain[MAX_POINTS]),
    .out_ready_i      (result_o.ready),
    .en_o             (en),
    .out_valid_o      (result_o.valid),
    .distinct_count_o (result_o.distinct_count),
    .table_overflow_o (result_o.table_overflow)
  );

endmodule

`default_nettype wire
